FILE: rtl/core/pcwe_pkg.sv
// ----------------------------------------------------------------------------
// pcwe_pkg
// Shared types and constants of the PID controller with wrapped error.
// ----------------------------------------------------------------------------
package pcwe_pkg;

  localparam int DataBits = 32;
  localparam int FracBits = 16;
  localparam int RemBits  = DataBits + 1;
  localparam int WideBits = RemBits + 1;
  localparam int AccBits  = 2 * DataBits - FracBits + 2;

  typedef logic signed [DataBits-1:0] data_t;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_DERIV_GAIN  = 3'd2,
    CFG_INPUT_MIN   = 3'd3,
    CFG_INPUT_MAX   = 3'd4,
    CFG_OUTPUT_MIN  = 3'd5,
    CFG_OUTPUT_MAX  = 3'd6,
    CFG_WRAP_ENABLE = 3'd7
  } cfg_index_t;

  localparam logic OP_CALCULATE = 1'b0;
  localparam logic OP_RESET     = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERROR,
    ST_DIVIDE,
    ST_FOLD,
    ST_MUL_I,
    ST_ACC_I,
    ST_MUL_P,
    ST_MUL_D,
    ST_SUM,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic form_error;
    logic div_step;
    logic fold;
    logic mul_i;
    logic acc_i;
    logic mul_p;
    logic mul_d;
    logic sum;
  } cmd_t;

  typedef struct packed {
    logic is_reset;
    logic wrap_active;
    logic div_done;
  } status_t;

endpackage

FILE: rtl/core/pid_controller_wrapped_error_top.sv
// ----------------------------------------------------------------------------
// pid_controller_wrapped_error_top
// PID step engine with circular error, anti-windup and output limits.
// ----------------------------------------------------------------------------
// The s_axis channel carries one request: calculate or reset. The m_axis
// channel returns one result per request with the drive, the current error
// and the error change, all signed Q16.16.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, as the block does not enforce it. One request
// is worked at a time. In wrap mode a restoring remainder unit takes one bit
// per cycle over 33 bits before the error is folded into range. A reset
// request skips the calculation and answers with zeros. The result is held
// on m_axis until taken; s_axis_tready stays low until then. Reset clears
// the registers, the stored error and the integral.
// ----------------------------------------------------------------------------
module pid_controller_wrapped_error_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // measurement, setpoint
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata   // drive, error_now, error_change
);
  import pcwe_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    busy, in_fire, out_fire;
  logic [31:0] drive, error_now, error_change;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = {error_change, error_now, drive};

  pcwe_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_fire, .status, .cmd, .busy,
    .result_valid(m_axis_tvalid)
  );

  pcwe_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index(cfg_index_t'(cfg_index)), .cfg_data,
    .in_operation(s_axis_tuser), .in_measurement(s_axis_tdata[31:0]),
    .in_setpoint(s_axis_tdata[63:32]), .cmd, .status,
    .drive, .error_now, .error_change
  );

endmodule

FILE: rtl/core/pcwe_ctrl.sv
// ----------------------------------------------------------------------------
// pcwe_ctrl
// Sequencer that steps the datapath through one control calculation.
// ----------------------------------------------------------------------------
module pcwe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  logic              out_fire,
  input  pcwe_pkg::status_t status,
  output pcwe_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              result_valid
);
  import pcwe_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_fire) state_next = ST_ERROR;
      ST_ERROR: begin
        if (status.is_reset) state_next = ST_OUTPUT;
        else if (status.wrap_active) state_next = ST_DIVIDE;
        else state_next = ST_MUL_I;
      end
      ST_DIVIDE: if (status.div_done) state_next = ST_FOLD;
      ST_FOLD:   state_next = ST_MUL_I;
      ST_MUL_I:  state_next = ST_ACC_I;
      ST_ACC_I:  state_next = ST_MUL_P;
      ST_MUL_P:  state_next = ST_MUL_D;
      ST_MUL_D:  state_next = ST_SUM;
      ST_SUM:    state_next = ST_OUTPUT;
      ST_OUTPUT: if (out_fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    busy = (state != ST_IDLE);
    result_valid = (state == ST_OUTPUT);
    unique case (state)
      ST_ERROR: begin
        if (status.is_reset) cmd.clear = 1'b1;
        else cmd.form_error = 1'b1;
      end
      ST_DIVIDE: cmd.div_step = !status.div_done;
      ST_FOLD:   cmd.fold = 1'b1;
      ST_MUL_I:  cmd.mul_i = 1'b1;
      ST_ACC_I:  cmd.acc_i = 1'b1;
      ST_MUL_P:  cmd.mul_p = 1'b1;
      ST_MUL_D:  cmd.mul_d = 1'b1;
      ST_SUM:    cmd.sum = 1'b1;
      default: ;
    endcase
  end

endmodule

FILE: rtl/core/pcwe_dp.sv
// ----------------------------------------------------------------------------
// pcwe_dp
// Datapath: configuration, error forming, restoring remainder, products,
// integral and drive.
// ----------------------------------------------------------------------------
module pcwe_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  pcwe_pkg::cfg_index_t cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_operation,
  input  logic [31:0]          in_measurement,
  input  logic [31:0]          in_setpoint,
  input  pcwe_pkg::cmd_t       cmd,
  output pcwe_pkg::status_t    status,
  output logic [31:0]          drive,
  output logic [31:0]          error_now,
  output logic [31:0]          error_change
);
  import pcwe_pkg::*;

  localparam int CntBits = $clog2(RemBits + 1);

  data_t       prop_gain, deriv_gain, in_min, in_max, out_min, out_max;
  logic [30:0] integ_gain;
  logic        wrap_enable;

  logic        op;
  data_t       meas, setp;
  data_t       last_error, integral_term;

  logic signed [RemBits:0]   err_wide;
  logic [RemBits-1:0]        dividend, rem, range_u;
  logic                      err_neg;
  logic [CntBits-1:0]        count;
  logic signed [2*DataBits:0] prod;
  logic signed [AccBits-1:0] acc;
  data_t       err, delta;

  logic signed [RemBits:0]   ref_c, range_s, err_f;
  logic signed [RemBits:0]   rem_s;
  logic [RemBits:0]          rem_trial;
  logic signed [2*DataBits:0] mul_a;
  logic signed [AccBits-1:0] term;
  logic signed [AccBits-1:0] acc_i, sum_v;

  function automatic data_t sat_w(input logic signed [RemBits:0] v);
    if (v > $signed({{2{1'b0}}, {(DataBits-1){1'b1}}})) return {1'b0, {(DataBits-1){1'b1}}};
    if (v < -$signed({{2{1'b0}}, 1'b1, {(DataBits-1){1'b0}}})) return {1'b1, {(DataBits-1){1'b0}}};
    return v[DataBits-1:0];
  endfunction

  function automatic data_t clamp_w(input logic signed [AccBits-1:0] v, input data_t lo,
                                    input data_t hi);
    logic signed [AccBits-1:0] t;
    t = v;
    if (t > AccBits'(hi)) t = AccBits'(hi);
    if (t < AccBits'(lo)) t = AccBits'(lo);
    return t[DataBits-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= '0; integ_gain <= '0; deriv_gain <= '0;
      in_min <= '0; in_max <= '0; out_min <= '0; out_max <= '0;
      wrap_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROP_GAIN:   prop_gain <= cfg_data;
        CFG_INTEG_GAIN:  integ_gain <= cfg_data[30:0];
        CFG_DERIV_GAIN:  deriv_gain <= cfg_data;
        CFG_INPUT_MIN:   in_min <= cfg_data;
        CFG_INPUT_MAX:   in_max <= cfg_data;
        CFG_OUTPUT_MIN:  out_min <= cfg_data;
        CFG_OUTPUT_MAX:  out_max <= cfg_data;
        CFG_WRAP_ENABLE: wrap_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ref_c = WideBits'(setp);
    if (in_max > in_min) begin
      if (setp > in_max) ref_c = WideBits'(in_max);
      if (ref_c < WideBits'(in_min)) ref_c = WideBits'(in_min);
    end
    range_s = WideBits'(in_max) - WideBits'(in_min);
    err_wide = ref_c - WideBits'(meas);
    rem_trial = {1'b0, rem[RemBits-2:0], dividend[RemBits-1]} - {1'b0, range_u};
    rem_s = err_neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
    err_f = rem_s;
    if ({rem, 1'b0} > {1'b0, range_u}) begin
      err_f = err_neg ? rem_s + range_s : rem_s - range_s;
    end
    mul_a = prod >>> FracBits;
    term = mul_a[AccBits-1:0];
    acc_i = term + AccBits'(integral_term);
    sum_v = acc + term;
  end

  assign status.is_reset    = op;
  assign status.wrap_active = wrap_enable && (range_s > 0);
  assign status.div_done    = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0; integral_term <= '0; count <= '0;
    end else begin
      if (cmd.load) begin
        op <= in_operation; meas <= in_measurement; setp <= in_setpoint;
      end
      if (cmd.clear) begin
        integral_term <= '0; err <= '0; delta <= '0; acc <= '0;
        drive <= '0; error_now <= '0; error_change <= '0;
      end
      if (cmd.form_error) begin
        err_neg  <= err_wide < 0;
        dividend <= err_wide < 0 ? RemBits'(-err_wide) : RemBits'(err_wide);
        range_u  <= RemBits'(range_s);
        rem      <= '0;
        count    <= CntBits'(RemBits);
        err      <= sat_w(err_wide);
      end
      if (cmd.div_step) begin
        dividend <= dividend << 1;
        count    <= count - 1'b1;
        if (!rem_trial[RemBits]) rem <= rem_trial[RemBits-1:0];
        else rem <= {rem[RemBits-2:0], dividend[RemBits-1]};
      end
      if (cmd.fold) err <= sat_w(err_f);
      if (cmd.mul_i) begin
        delta <= sat_w(WideBits'(err) - WideBits'(last_error));
        last_error <= err;
        prod <= $signed({1'b0, integ_gain}) * err;
      end
      if (cmd.acc_i) begin
        if (integ_gain != '0) begin
          integral_term <= clamp_w(acc_i, out_min, out_max);
          acc <= AccBits'(clamp_w(acc_i, out_min, out_max));
        end else begin
          acc <= '0;
        end
        prod <= prop_gain * err;
      end
      if (cmd.mul_p) begin
        acc  <= sum_v;
        prod <= deriv_gain * delta;
      end
      if (cmd.mul_d) acc <= sum_v;
      if (cmd.sum) begin
        drive <= clamp_w(acc, out_min, out_max);
        error_now <= err;
        error_change <= delta;
      end
    end
  end

endmodule

FILE: rtl/core/pcwe_checker.sv
// ----------------------------------------------------------------------------
// pcwe_checker
// Port-level checks of the PID controller.
// ----------------------------------------------------------------------------
module pcwe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("not busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid) else $error("valid after reset");

endmodule

bind pid_controller_wrapped_error_top pcwe_checker u_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);
